// File: rtl/rtimu_pkg.sv
`timescale 1ns / 1ps
package rtimu_pkg;

	localparam int IDX_W   = 20;
	localparam int SZ_W    = 9;
	localparam int MAT_W   = 27;
	localparam int ENT_W   = 3;
	localparam int DIV_W   = ((IDX_W > 10) ? IDX_W : 10) + 3;
	localparam int T_W     = DIV_W + 1;
	localparam int R_W     = SZ_W + 1;
	localparam int B_W     = R_W + 1;
	localparam int P_W     = 3 * SZ_W + 1;
	localparam int TDATA_W = ((IDX_W + 7) / 8) * 8;
	localparam int ADDR_W  = 2;

	typedef enum logic [ADDR_W-1:0] {
		REG_SIZE_H = 2'd0,
		REG_SIZE_K = 2'd1,
		REG_SIZE_L = 2'd2,
		REG_TWIN   = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [SZ_W-1:0]   eh;
		logic [SZ_W-1:0]   ek;
		logic [SZ_W-1:0]   el;
		logic [2*SZ_W-1:0] nhk;
		logic [MAT_W-1:0]  matrix;
	} cfg_t;

	typedef struct packed {
		logic [SZ_W-1:0]  rem;
		logic [DIV_W-1:0] dq;
	} div_t;

	// one restoring division step, quotient bits shift in behind the dividend
	function automatic div_t div_step(div_t x, logic [SZ_W-1:0] d);
		logic [SZ_W:0] trial;
		div_t y;
		trial = {x.rem, x.dq[DIV_W-1]};
		y.dq = {x.dq[DIV_W-2:0], 1'b0};
		if (trial >= {1'b0, d}) begin
			y.rem = SZ_W'(trial - {1'b0, d});
			y.dq[0] = 1'b1;
		end else begin
			y.rem = trial[SZ_W-1:0];
		end
		return y;
	endfunction

endpackage

// File: rtl/rtimu_split.sv
`timescale 1ns / 1ps
module rtimu_split (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                adv,
	input  rtimu_pkg::cfg_t                     cfg,
	input  logic                                in_valid,
	input  logic [rtimu_pkg::IDX_W-1:0]         in_idx,
	output logic                                out_valid,
	output logic signed [rtimu_pkg::T_W-1:0]    g0,
	output logic signed [rtimu_pkg::T_W-1:0]    g1,
	output logic signed [rtimu_pkg::T_W-1:0]    g2
);

	localparam int N = rtimu_pkg::DIV_W;

	logic [N-1:0]             va_s;
	rtimu_pkg::div_t          da_s [N];
	logic [N-1:0]             vb_s;
	rtimu_pkg::div_t          db_s [N];
	logic [rtimu_pkg::SZ_W-1:0] hb_s [N];
	rtimu_pkg::div_t          a_init;
	rtimu_pkg::div_t          b_init;

	logic                     vf_s;
	logic signed [rtimu_pkg::T_W-1:0] g0_sf, g1_sf, g2_sf;

	assign a_init.rem = '0;
	assign a_init.dq  = rtimu_pkg::DIV_W'(in_idx);
	assign b_init.rem = '0;
	assign b_init.dq  = da_s[N-1].dq;

	// n / size_h
	for (genvar i = 0; i < N; i++) begin : g_div_a
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				va_s[i] <= 1'b0;
			end else if (adv) begin
				va_s[i] <= (i == 0) ? in_valid : va_s[(i == 0) ? 0 : i-1];
			end
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				da_s[i] <= rtimu_pkg::div_step((i == 0) ? a_init : da_s[(i == 0) ? 0 : i-1],
					cfg.eh);
			end
		end
	end

	// quotient / size_k, h rides along
	for (genvar i = 0; i < N; i++) begin : g_div_b
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vb_s[i] <= 1'b0;
			end else if (adv) begin
				vb_s[i] <= (i == 0) ? va_s[N-1] : vb_s[(i == 0) ? 0 : i-1];
			end
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				db_s[i] <= rtimu_pkg::div_step((i == 0) ? b_init : db_s[(i == 0) ? 0 : i-1],
					cfg.ek);
				hb_s[i] <= (i == 0) ? da_s[N-1].rem : hb_s[(i == 0) ? 0 : i-1];
			end
		end
	end

	logic [rtimu_pkg::SZ_W-1:0] k_raw;
	logic [rtimu_pkg::DIV_W-1:0] l_raw;
	logic signed [rtimu_pkg::T_W-1:0] kx, ekx, lx, elx;

	always_comb begin
		k_raw = db_s[N-1].rem;
		l_raw = db_s[N-1].dq;
		kx  = signed'(rtimu_pkg::T_W'(k_raw));
		ekx = signed'(rtimu_pkg::T_W'(cfg.ek));
		lx  = signed'(rtimu_pkg::T_W'(l_raw));
		elx = signed'(rtimu_pkg::T_W'(cfg.el));
	end

	// fold k and l to signed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vf_s <= 1'b0;
		end else if (adv) begin
			vf_s <= vb_s[N-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			g0_sf <= signed'(rtimu_pkg::T_W'(hb_s[N-1]));
			g1_sf <= (k_raw >= (cfg.ek >> 1)) ? kx - ekx : kx;
			g2_sf <= (l_raw >= rtimu_pkg::DIV_W'(cfg.el >> 1)) ? lx - elx : lx;
		end
	end

	assign out_valid = vf_s;
	assign g0 = g0_sf;
	assign g1 = g1_sf;
	assign g2 = g2_sf;

endmodule

// File: rtl/rtimu_twin.sv
`timescale 1ns / 1ps
module rtimu_twin (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                adv,
	input  rtimu_pkg::cfg_t                     cfg,
	input  logic                                in_valid,
	input  logic signed [rtimu_pkg::T_W-1:0]    g0,
	input  logic signed [rtimu_pkg::T_W-1:0]    g1,
	input  logic signed [rtimu_pkg::T_W-1:0]    g2,
	output logic                                out_valid,
	output logic signed [rtimu_pkg::R_W-1:0]    t0,
	output logic signed [rtimu_pkg::R_W-1:0]    t1,
	output logic signed [rtimu_pkg::R_W-1:0]    t2
);

	localparam int N = rtimu_pkg::DIV_W;

	logic signed [rtimu_pkg::T_W-1:0] gv [3];
	logic signed [rtimu_pkg::T_W-1:0] prod [3];
	logic [rtimu_pkg::SZ_W-1:0]       dvs [3];

	logic                             vm_s;
	logic signed [rtimu_pkg::T_W-1:0] tm_s [3];
	logic                             va_s;
	logic [rtimu_pkg::DIV_W-1:0]      mag_s [3];
	logic [2:0]                       neg_s;
	logic [N-1:0]                     vl_s;
	rtimu_pkg::div_t                  dl_s [3][N];
	logic [2:0]                       sl_s [N];
	logic                             vr_s;
	logic signed [rtimu_pkg::R_W-1:0] tr_s [3];

	assign gv[0] = g0;
	assign gv[1] = g1;
	assign gv[2] = g2;
	assign dvs[0] = cfg.eh;
	assign dvs[1] = cfg.ek;
	assign dvs[2] = cfg.el;

	// matrix rows
	always_comb begin
		for (int r = 0; r < 3; r++) begin
			prod[r] = '0;
			for (int c = 0; c < 3; c++) begin
				prod[r] = prod[r] + rtimu_pkg::T_W'(signed'(
					cfg.matrix[rtimu_pkg::ENT_W*(3*r+c) +: rtimu_pkg::ENT_W])) * gv[c];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vm_s <= 1'b0;
			va_s <= 1'b0;
			vr_s <= 1'b0;
		end else if (adv) begin
			vm_s <= in_valid;
			va_s <= vm_s;
			vr_s <= vl_s[N-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int r = 0; r < 3; r++) begin
				tm_s[r]  <= prod[r];
				mag_s[r] <= rtimu_pkg::DIV_W'((tm_s[r] < 0) ? -tm_s[r] : tm_s[r]);
				neg_s[r] <= tm_s[r][rtimu_pkg::T_W-1];
			end
		end
	end

	// magnitude remainder, three lanes
	for (genvar i = 0; i < N; i++) begin : g_mod
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vl_s[i] <= 1'b0;
			end else if (adv) begin
				vl_s[i] <= (i == 0) ? va_s : vl_s[(i == 0) ? 0 : i-1];
			end
		end
		for (genvar r = 0; r < 3; r++) begin : g_lane
			rtimu_pkg::div_t init;
			assign init.rem = '0;
			assign init.dq  = mag_s[r];
			always_ff @(posedge clk) begin
				if (adv) begin
					dl_s[r][i] <= rtimu_pkg::div_step(
						(i == 0) ? init : dl_s[r][(i == 0) ? 0 : i-1], dvs[r]);
				end
			end
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				sl_s[i] <= (i == 0) ? neg_s : sl_s[(i == 0) ? 0 : i-1];
			end
		end
	end

	// remainder takes the sign of the dividend
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int r = 0; r < 3; r++) begin
				tr_s[r] <= sl_s[N-1][r]
					? -signed'(rtimu_pkg::R_W'(dl_s[r][N-1].rem))
					: signed'(rtimu_pkg::R_W'(dl_s[r][N-1].rem));
			end
		end
	end

	assign out_valid = vr_s;
	assign t0 = tr_s[0];
	assign t1 = tr_s[1];
	assign t2 = tr_s[2];

endmodule

// File: rtl/rtimu_pack.sv
`timescale 1ns / 1ps
module rtimu_pack (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                adv,
	input  rtimu_pkg::cfg_t                     cfg,
	input  logic                                in_valid,
	input  logic signed [rtimu_pkg::R_W-1:0]    t0,
	input  logic signed [rtimu_pkg::R_W-1:0]    t1,
	input  logic signed [rtimu_pkg::R_W-1:0]    t2,
	output logic                                out_valid,
	output logic [rtimu_pkg::IDX_W-1:0]         idx,
	output logic                                mate
);

	logic mate_c;
	logic signed [rtimu_pkg::B_W-1:0] t1x, t2x, ekx, elx, b_c, c_c;
	logic signed [rtimu_pkg::R_W-1:0] a_c;

	logic                          v1_s, v2_s;
	logic                          mate_s1, mate_s2;
	logic [rtimu_pkg::SZ_W-1:0]    a_s1, b_s1, c_s1, a_s2;
	logic [2*rtimu_pkg::SZ_W-1:0]  pb_s2;
	logic [3*rtimu_pkg::SZ_W-1:0]  pc_s2;
	logic [rtimu_pkg::P_W-1:0]     sum;

	always_comb begin
		mate_c = !((t0 > 0) || (t0 == 0 && t1 > 0) || (t0 == 0 && t1 == 0 && t2 >= 0));
		t1x = rtimu_pkg::B_W'(t1);
		t2x = rtimu_pkg::B_W'(t2);
		ekx = signed'(rtimu_pkg::B_W'(cfg.ek));
		elx = signed'(rtimu_pkg::B_W'(cfg.el));
		a_c = mate_c ? -t0 : t0;
		if (mate_c) begin
			b_c = (t1x > 0) ? ekx - t1x : -t1x;
			c_c = (t2x > 0) ? elx - t2x : -t2x;
		end else begin
			b_c = (t1x < 0) ? ekx + t1x : t1x;
			c_c = (t2x < 0) ? elx + t2x : t2x;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s <= 1'b0;
			v2_s <= 1'b0;
		end else if (adv) begin
			v1_s <= in_valid;
			v2_s <= v1_s;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mate_s1 <= mate_c;
			a_s1    <= a_c[rtimu_pkg::SZ_W-1:0];
			b_s1    <= b_c[rtimu_pkg::SZ_W-1:0];
			c_s1    <= c_c[rtimu_pkg::SZ_W-1:0];
			mate_s2 <= mate_s1;
			a_s2    <= a_s1;
			pb_s2   <= b_s1 * cfg.eh;
			pc_s2   <= c_s1 * cfg.nhk;
		end
	end

	assign sum = rtimu_pkg::P_W'(a_s2) + rtimu_pkg::P_W'(pb_s2) + rtimu_pkg::P_W'(pc_s2);
	assign out_valid = v2_s;
	assign idx  = rtimu_pkg::IDX_W'(sum);
	assign mate = mate_s2;

endmodule

// File: rtl/reflection_twin_index_map_unit.sv
`timescale 1ns / 1ps
// reflection twin index map
// input stream: s_axis_* carries one linear reflection index per transaction
// output stream: m_axis_* carries the twinned linear index, tuser set when the
// friedel mate was taken
// configuration: cfg_wr_en/cfg_addr/cfg_wdata write size_h, size_k, size_l and
// the twin matrix; write only while no transaction is in flight
// path: two chained bit-per-stage dividers for h, k, l and one bit-per-stage
// remainder unit with three lanes for the twinned row values
// throughput: one transaction per cycle while the output is not stalled
// reset: pipeline emptied, registers return to identity matrix, sizes 1, 2, 2
// stall: when the output holds a result that is not taken, the whole pipeline
// freezes and s_axis_tready drops; nothing is lost or repeated
module reflection_twin_index_map_unit (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_axis_tvalid,
	output logic                                  s_axis_tready,
	input  logic [rtimu_pkg::TDATA_W-1:0]         s_axis_tdata,  // reflection_index
	output logic                                  m_axis_tvalid,
	input  logic                                  m_axis_tready,
	output logic [rtimu_pkg::TDATA_W-1:0]         m_axis_tdata,  // twin_index
	output logic                                  m_axis_tuser,  // friedel_mate
	input  logic                                  cfg_wr_en,
	input  logic [rtimu_pkg::ADDR_W-1:0]          cfg_addr,
	input  logic [rtimu_pkg::MAT_W-1:0]           cfg_wdata
);

	logic [rtimu_pkg::SZ_W-1:0]  size_h_q, size_k_q, size_l_q;
	logic [rtimu_pkg::MAT_W-1:0] matrix_q;
	logic [2*rtimu_pkg::SZ_W-1:0] nhk_q;
	logic [rtimu_pkg::SZ_W-1:0]  eh, ek, el;
	rtimu_pkg::cfg_t             cfg;
	logic                        adv;

	logic                                sp_valid, tw_valid, pk_valid;
	logic signed [rtimu_pkg::T_W-1:0]    g0, g1, g2;
	logic signed [rtimu_pkg::R_W-1:0]    t0, t1, t2;
	logic [rtimu_pkg::IDX_W-1:0]         pk_idx;
	logic                                pk_mate;

	logic                                out_valid_q;
	logic [rtimu_pkg::IDX_W-1:0]         out_idx_q;
	logic                                out_mate_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_h_q <= rtimu_pkg::SZ_W'(1);
			size_k_q <= rtimu_pkg::SZ_W'(2);
			size_l_q <= rtimu_pkg::SZ_W'(2);
			matrix_q <= rtimu_pkg::MAT_W'(27'h1001001);
		end else if (cfg_wr_en) begin
			unique case (rtimu_pkg::cfg_reg_t'(cfg_addr))
				rtimu_pkg::REG_SIZE_H: size_h_q <= cfg_wdata[rtimu_pkg::SZ_W-1:0];
				rtimu_pkg::REG_SIZE_K: size_k_q <= cfg_wdata[rtimu_pkg::SZ_W-1:0];
				rtimu_pkg::REG_SIZE_L: size_l_q <= cfg_wdata[rtimu_pkg::SZ_W-1:0];
				rtimu_pkg::REG_TWIN:   matrix_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// a size of zero acts as one
	assign eh = (size_h_q == '0) ? rtimu_pkg::SZ_W'(1) : size_h_q;
	assign ek = (size_k_q == '0) ? rtimu_pkg::SZ_W'(1) : size_k_q;
	assign el = (size_l_q == '0) ? rtimu_pkg::SZ_W'(1) : size_l_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nhk_q <= (2*rtimu_pkg::SZ_W)'(2);
		end else begin
			nhk_q <= eh * ek;
		end
	end

	assign cfg.eh     = eh;
	assign cfg.ek     = ek;
	assign cfg.el     = el;
	assign cfg.nhk    = nhk_q;
	assign cfg.matrix = matrix_q;

	assign adv = !out_valid_q || m_axis_tready;
	assign s_axis_tready = adv;

	rtimu_split u_split (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.cfg       (cfg),
		.in_valid  (s_axis_tvalid),
		.in_idx    (s_axis_tdata[rtimu_pkg::IDX_W-1:0]),
		.out_valid (sp_valid),
		.g0        (g0),
		.g1        (g1),
		.g2        (g2)
	);

	rtimu_twin u_twin (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.cfg       (cfg),
		.in_valid  (sp_valid),
		.g0        (g0),
		.g1        (g1),
		.g2        (g2),
		.out_valid (tw_valid),
		.t0        (t0),
		.t1        (t1),
		.t2        (t2)
	);

	rtimu_pack u_pack (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.cfg       (cfg),
		.in_valid  (tw_valid),
		.t0        (t0),
		.t1        (t1),
		.t2        (t2),
		.out_valid (pk_valid),
		.idx       (pk_idx),
		.mate      (pk_mate)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= pk_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_idx_q  <= pk_idx;
			out_mate_q <= pk_mate;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = rtimu_pkg::TDATA_W'(out_idx_q);
	assign m_axis_tuser  = out_mate_q;

endmodule

// File: rtl/rtimu_checker.sv
`timescale 1ns / 1ps
module rtimu_checker (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_axis_tready,
	input  logic                                  m_axis_tvalid,
	input  logic                                  m_axis_tready,
	input  logic [rtimu_pkg::TDATA_W-1:0]         m_axis_tdata,
	input  logic                                  m_axis_tuser
);

	// result held until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("output transaction dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("output payload changed while stalled");

	// empty output never blocks input
	a_in_open: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input blocked with empty output");

	// a stalled output freezes the pipeline
	a_in_stall: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
		else $error("input taken while output stalled");

endmodule

bind reflection_twin_index_map_unit rtimu_checker u_rtimu_checker (.*);

// File: tb/reflection_twin_index_map_checker.sv
`timescale 1ns / 1ps
module reflection_twin_index_map_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	input  logic                              s_axis_tready,
	input  logic [rtimu_pkg::TDATA_W-1:0]     s_axis_tdata,
	input  logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	input  logic [rtimu_pkg::TDATA_W-1:0]     m_axis_tdata,
	input  logic                              m_axis_tuser,
	input  logic                              cfg_wr_en,
	input  logic [rtimu_pkg::ADDR_W-1:0]      cfg_addr,
	input  logic [rtimu_pkg::MAT_W-1:0]       cfg_wdata,
	output int                                fail_count,
	output int                                pending_count
);
	import rtimu_pkg::*;

	typedef struct packed {
		logic [IDX_W-1:0] twin_index;
		logic             friedel_mate;
	} twin_result_t;

	logic [SZ_W-1:0]  grid_h, grid_k, grid_l;
	logic [MAT_W-1:0] twin_mat;
	twin_result_t     expected_twins[$];

	function automatic longint entry_of(logic [MAT_W-1:0] m, int i);
		logic signed [ENT_W-1:0] e;
		e = m[3*i +: 3];
		return longint'(e);
	endfunction

	function automatic twin_result_t map_reflection(logic [IDX_W-1:0] idx);
		longint nh, nk, nl, n, tn;
		longint g[3];
		longint t[3];
		logic mate;
		twin_result_t r;
		nh = (grid_h == 0) ? 1 : longint'(grid_h);
		nk = (grid_k == 0) ? 1 : longint'(grid_k);
		nl = (grid_l == 0) ? 1 : longint'(grid_l);
		n = longint'(idx);
		g[0] = n % nh;
		g[1] = (n / nh) % nk;
		g[2] = n / (nh * nk);
		if (g[1] >= nk / 2) g[1] -= nk;
		if (g[2] >= nl / 2) g[2] -= nl;
		for (int row = 0; row < 3; row++)
			t[row] = entry_of(twin_mat, 3*row) * g[0] + entry_of(twin_mat, 3*row+1) * g[1]
				+ entry_of(twin_mat, 3*row+2) * g[2];
		t[0] %= nh;
		t[1] %= nk;
		t[2] %= nl;
		mate = !((t[0] > 0) || (t[0] == 0 && t[1] > 0) || (t[0] == 0 && t[1] == 0 && t[2] >= 0));
		if (!mate)
			tn = t[0] + ((nk + t[1]) % nk) * nh + ((nl + t[2]) % nl) * nh * nk;
		else
			tn = -t[0] + ((nk - t[1]) % nk) * nh + ((nl - t[2]) % nl) * nh * nk;
		r.twin_index = tn[IDX_W-1:0];
		r.friedel_mate = mate;
		return r;
	endfunction

	assign pending_count = expected_twins.size();

	always @(posedge clk or negedge arst_n) begin
		twin_result_t exp_r;
		if (!arst_n) begin
			grid_h = SZ_W'(1);
			grid_k = SZ_W'(2);
			grid_l = SZ_W'(2);
			twin_mat = 27'h1001001;
			expected_twins.delete();
			fail_count = 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				expected_twins.push_back(map_reflection(s_axis_tdata[IDX_W-1:0]));
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_twins.size() == 0) begin
					$display("%0t unexpected transaction: actual %h/%b", $time,
						m_axis_tdata[IDX_W-1:0], m_axis_tuser);
					fail_count++;
				end else begin
					exp_r = expected_twins.pop_front();
					if (m_axis_tdata[IDX_W-1:0] !== exp_r.twin_index) begin
						$display("%0t twin_index expected %h actual %h", $time,
							exp_r.twin_index, m_axis_tdata[IDX_W-1:0]);
						fail_count++;
					end
					if (m_axis_tuser !== exp_r.friedel_mate) begin
						$display("%0t friedel_mate expected %b actual %b", $time,
							exp_r.friedel_mate, m_axis_tuser);
						fail_count++;
					end
				end
			end
			if (cfg_wr_en) begin
				case (cfg_reg_t'(cfg_addr))
					REG_SIZE_H: grid_h = cfg_wdata[SZ_W-1:0];
					REG_SIZE_K: grid_k = cfg_wdata[SZ_W-1:0];
					REG_SIZE_L: grid_l = cfg_wdata[SZ_W-1:0];
					REG_TWIN:   twin_mat = cfg_wdata;
					default: ;
				endcase
			end
		end
	end
endmodule

// File: tb/reflection_twin_index_map_unit_tb.sv
`timescale 1ns / 1ps
module reflection_twin_index_map_unit_tb;
	import rtimu_pkg::*;

	localparam int CYCLE_LIMIT = 400000;

	logic                 clk;
	logic                 arst_n;
	logic                 s_axis_tvalid;
	logic                 s_axis_tready;
	logic [TDATA_W-1:0]   s_axis_tdata;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready;
	logic [TDATA_W-1:0]   m_axis_tdata;
	logic                 m_axis_tuser;
	logic                 cfg_wr_en;
	logic [ADDR_W-1:0]    cfg_addr;
	logic [MAT_W-1:0]     cfg_wdata;
	int                   fail_count;
	int                   pending_count;
	int                   cycle_count;
	bit                   long_hold;
	logic [SZ_W-1:0]      cur_h, cur_k, cur_l;

	reflection_twin_index_map_unit u_top (.*);

	reflection_twin_index_map_checker u_checker (.*);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	initial begin
		cycle_count = 0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count > CYCLE_LIMIT) begin
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	// receiver: random stalls, one long hold while the pipeline fills
	initial begin
		int gap;
		m_axis_tready = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (long_hold) begin
				m_axis_tready <= 0;
				repeat (300) @(negedge clk);
				long_hold = 0;
			end
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
			if (gap > 0) begin
				m_axis_tready <= 0;
				repeat (gap - 1) @(negedge clk);
				@(negedge clk);
			end
			m_axis_tready <= 1;
			do @(posedge clk); while (!m_axis_tvalid && !long_hold);
		end
	end

	task automatic write_reg(cfg_reg_t r, logic [MAT_W-1:0] v);
		@(negedge clk);
		cfg_wr_en <= 1;
		cfg_addr <= r;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_wr_en <= 0;
	endtask

	task automatic set_grid(logic [SZ_W-1:0] h, logic [SZ_W-1:0] k, logic [SZ_W-1:0] l,
			logic [MAT_W-1:0] m);
		s_axis_tvalid <= 0;
		while (pending_count != 0) @(negedge clk);
		repeat (100) @(negedge clk);
		write_reg(REG_SIZE_H, MAT_W'(h));
		write_reg(REG_SIZE_K, MAT_W'(k));
		write_reg(REG_SIZE_L, MAT_W'(l));
		write_reg(REG_TWIN, m);
		cur_h = h; cur_k = k; cur_l = l;
	endtask

	task automatic send_index(logic [IDX_W-1:0] idx, bit no_gap);
		int gap;
		gap = (no_gap || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
		if (gap > 0) begin
			s_axis_tvalid <= 0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1;
		s_axis_tdata <= TDATA_W'(idx);
		do @(posedge clk); while (!s_axis_tready);
		@(negedge clk);
	endtask

	function automatic logic [IDX_W-1:0] grid_index();
		longint total;
		total = longint'(cur_h == 0 ? 1 : cur_h) * (cur_k == 0 ? 1 : cur_k)
			* (cur_l == 0 ? 1 : cur_l);
		if ($urandom_range(0, 9) == 0 || total > 64'd1048576) return IDX_W'($urandom);
		return IDX_W'($urandom_range(0, 32'(total - 1)));
	endfunction

	initial begin
		s_axis_tvalid = 0;
		s_axis_tdata = '0;
		cfg_wr_en = 0;
		cfg_addr = '0;
		cfg_wdata = '0;
		long_hold = 0;
		cur_h = SZ_W'(1); cur_k = SZ_W'(2); cur_l = SZ_W'(2);
		arst_n = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// reset settings, identity matrix
		send_index('0, 0);
		send_index(20'hFFFFF, 0);
		send_index(20'd3, 0);
		set_grid(9'd8, 9'd6, 9'd4, 27'h1001001);
		send_index('0, 0);
		send_index(20'd191, 0);
		send_index(20'hFFFFF, 0);
		send_index(20'hAAAAA, 0);
		send_index(20'h55555, 0);
		// negated matrix, zero and single sizes
		set_grid(9'd0, 9'd1, 9'd1, 27'h7007007);
		for (int i = 0; i < 4; i++) send_index(IDX_W'(i), 0);
		set_grid(9'd511, 9'd511, 9'd511, 27'h4924924);
		send_index('0, 0);
		send_index(20'hFFFFF, 0);
		send_index(20'd300000, 0);
		set_grid(9'd256, 9'd256, 9'd16, 27'h3FFFFFF);
		send_index(20'hFFFFF, 0);
		send_index(20'd12345, 0);
		set_grid(9'd1, 9'd2, 9'd2, 27'h0000000);
		send_index(20'd5, 0);
		send_index(20'd2, 0);

		for (int phase = 0; phase < 12; phase++) begin
			logic [MAT_W-1:0] m;
			case (phase % 4)
				0: m = MAT_W'($urandom);
				1: m = 27'h1001001;
				2: m = {3'd0, 3'd1, 3'd0, 3'd1, 3'd0, 3'd0, 3'd0, 3'd0, 3'd7};
				default: m = MAT_W'($urandom);
			endcase
			if (phase == 11)
				set_grid(9'd256, 9'd256, 9'd256, m);
			else
				set_grid(SZ_W'($urandom_range(1, 40)), SZ_W'($urandom_range(1, 40)),
					SZ_W'($urandom_range(1, 40)), m);
			if (phase == 3) long_hold = 1;
			for (int i = 0; i < ((phase == 3) ? 120 : 46); i++)
				send_index(grid_index(), phase == 3);
		end

		s_axis_tvalid <= 0;
		while (pending_count != 0) @(negedge clk);
		repeat (100) @(negedge clk);
		if (fail_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end
endmodule
